// ===== rtl/pid_filtered_derivative_macros.svh =====
// Assertion helpers shared by the RTL of the filtered-derivative PID block.
// Both expect signals named clock and reset in the module that uses them.
`ifndef PID_FILTERED_DERIVATIVE_MACROS_SVH
`define PID_FILTERED_DERIVATIVE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PFD_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("pfd: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define PFD_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("pfd: next-cycle check failed");

`endif

// ===== rtl/pfd_pkg.sv =====
`timescale 1ns / 1ps
package pfd_pkg;

   // Configuration register indexes.
   localparam logic [2:0] CSR_GAIN_P       = 3'd0;
   localparam logic [2:0] CSR_GAIN_I       = 3'd1;
   localparam logic [2:0] CSR_GAIN_D       = 3'd2;
   localparam logic [2:0] CSR_ERROR_MAX    = 3'd3;
   localparam logic [2:0] CSR_SEP_BAND     = 3'd4;
   localparam logic [2:0] CSR_INTEGRAL_MAX = 3'd5;
   localparam logic [2:0] CSR_OUTPUT_LIMIT = 3'd6;
   localparam logic [2:0] CSR_MODE_FLAGS   = 3'd7;

   localparam logic [14:0] OUTPUT_LIMIT_RST = 15'd30000;
   localparam logic [2:0]  MODE_FLAGS_RST   = 3'd6;

   // Mode flag bit positions.
   localparam int MODE_ERR_CLAMP = 0;
   localparam int MODE_SEPARATE  = 1;
   localparam int MODE_INT_CLAMP = 2;

   // Butterworth low-pass coefficients, Q2.30. The feedback terms are stored negated.
   localparam logic signed [31:0] COEF_B0  = 32'sd72429549;
   localparam logic signed [31:0] COEF_B1  = 32'sd144859098;
   localparam logic signed [31:0] COEF_B2  = 32'sd72429549;
   localparam logic signed [31:0] COEF_NA1 = 32'sd1227265970;
   localparam logic signed [31:0] COEF_NA2 = -32'sd443242341;

   localparam logic signed [31:0] Y_MAX     = 32'sd2147483647;
   localparam logic signed [47:0] INTEG_HI  = 48'sh7FFF_FFFF_FFFF;
   localparam logic signed [47:0] INTEG_LO  = 48'sh8000_0000_0000;

   // Multiplier operand pairs.
   localparam logic [2:0] MUL_B0D  = 3'd0;
   localparam logic [2:0] MUL_B1H0 = 3'd1;
   localparam logic [2:0] MUL_B2H1 = 3'd2;
   localparam logic [2:0] MUL_A1Y0 = 3'd3;
   localparam logic [2:0] MUL_A2Y1 = 3'd4;
   localparam logic [2:0] MUL_KIE  = 3'd5;
   localparam logic [2:0] MUL_KPE  = 3'd6;
   localparam logic [2:0] MUL_KDY  = 3'd7;

   // Accumulator operations.
   localparam logic [2:0] ACC_HOLD   = 3'd0;
   localparam logic [2:0] ACC_LOAD   = 3'd1;
   localparam logic [2:0] ACC_ADD    = 3'd2;
   localparam logic [2:0] ACC_LOAD12 = 3'd3;
   localparam logic [2:0] ACC_ADD12  = 3'd4;
   localparam logic [2:0] ACC_ADDI   = 3'd5;
   localparam logic [2:0] ACC_ADDKD  = 3'd6;

   // Microprogram addresses.
   localparam logic [3:0] ST_PREP   = 4'd0;
   localparam logic [3:0] ST_F0     = 4'd1;
   localparam logic [3:0] ST_F1     = 4'd2;
   localparam logic [3:0] ST_F2     = 4'd3;
   localparam logic [3:0] ST_F3     = 4'd4;
   localparam logic [3:0] ST_F4     = 4'd5;
   localparam logic [3:0] ST_F5     = 4'd6;
   localparam logic [3:0] ST_YUPD   = 4'd7;
   localparam logic [3:0] ST_KP     = 4'd8;
   localparam logic [3:0] ST_SUMI   = 4'd9;
   localparam logic [3:0] ST_SUMD   = 4'd10;
   localparam logic [3:0] ST_OUT    = 4'd11;
   localparam logic [3:0] ST_CLEAR  = 4'd12;

   typedef struct packed {
      logic signed [31:0] gain_p;
      logic signed [31:0] gain_i;
      logic signed [31:0] gain_d;
      logic [15:0]        error_max;
      logic [15:0]        separation_band;
      logic [14:0]        integral_max;
      logic [14:0]        output_limit;
      logic [2:0]         mode_flags;
   } cfg_type;

   typedef struct packed {
      logic       mul_en;
      logic [2:0] mul_sel;
      logic [2:0] acc_op;
      logic       prep;
      logic       y_upd;
      logic       int_add;
      logic       int_clamp;
      logic       clr_int;
      logic       emit;
      logic       last;
      logic       jmp_func;
      logic [3:0] jmp_to;
   } uword_type;

   typedef struct packed {
      logic      load;
      logic      en;
      uword_type uw;
   } ctl_type;

   // Control store. Products land in the product register as their step ends; filter
   // and proportional products are folded into the accumulator the step after.
   function automatic uword_type ucode(input logic [3:0] step);
      uword_type w;
      w = '0;
      case (step)
         ST_PREP: begin
            w.prep     = 1'b1;
            w.jmp_func = 1'b1;
            w.jmp_to   = ST_CLEAR;
         end
         ST_F0: begin
            w.mul_en = 1'b1; w.mul_sel = MUL_B0D;
         end
         ST_F1: begin
            w.mul_en = 1'b1; w.mul_sel = MUL_B1H0; w.acc_op = ACC_LOAD12;
         end
         ST_F2: begin
            w.mul_en = 1'b1; w.mul_sel = MUL_B2H1; w.acc_op = ACC_ADD12;
         end
         ST_F3: begin
            w.mul_en = 1'b1; w.mul_sel = MUL_A1Y0; w.acc_op = ACC_ADD12;
         end
         ST_F4: begin
            w.mul_en = 1'b1; w.mul_sel = MUL_A2Y1; w.acc_op = ACC_ADD;
         end
         ST_F5: begin
            w.mul_en = 1'b1; w.mul_sel = MUL_KIE; w.acc_op = ACC_ADD;
         end
         ST_YUPD: begin
            w.mul_en = 1'b1; w.mul_sel = MUL_KPE;
            w.y_upd  = 1'b1; w.int_add = 1'b1;
         end
         ST_KP: begin
            w.mul_en    = 1'b1; w.mul_sel = MUL_KDY; w.acc_op = ACC_LOAD;
            w.int_clamp = 1'b1;
         end
         ST_SUMI: begin
            w.acc_op = ACC_ADDI;
         end
         ST_SUMD: begin
            w.acc_op = ACC_ADDKD;
         end
         ST_OUT: begin
            w.emit = 1'b1; w.last = 1'b1;
         end
         ST_CLEAR: begin
            w.clr_int = 1'b1; w.emit = 1'b1; w.last = 1'b1;
         end
         default: begin
            w.last = 1'b1;
         end
      endcase
      return w;
   endfunction

endpackage

// ===== rtl/pfd_if.sv =====
`timescale 1ns / 1ps
interface pfd_req_if;
   logic               valid;
   logic               ready;
   logic               func;
   logic signed [15:0] target;
   logic signed [15:0] measure;

   modport source (output valid, output func, output target, output measure, input ready);
   modport sink   (input valid, input func, input target, input measure, output ready);
endinterface

interface pfd_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] drive;

   modport source (output valid, output drive, input ready);
   modport sink   (input valid, input drive, output ready);
endinterface

// ===== rtl/pid_filtered_derivative.sv =====
`timescale 1ns / 1ps
// Positional PID controller with a second-order low-pass on the derivative.
// req_ch carries one beat per sample: func 0 runs a control step on target
// and measure, func 1 zeroes the integrator and repeats the last drive.
// rsp_ch returns exactly one drive beat for each request beat, in order.
// Configuration is written via csr_we / csr_index / csr_wdata, one register
// per cycle, by the user only while no request is in flight; not enforced.
// A control step is an accept cycle followed by twelve microcode steps, run
// in turn because every filter tap and gain product goes through the single
// shared 32x32 multiplier. The final step loads the drive into the output
// register. A clear beat runs the prep step and then jumps to the clear step.
// The next request is accepted as soon as the microprogram finishes, even if
// the previous drive is still waiting in the output register; only the final
// step waits when that register is full and its beat is not being taken.
// Synchronous reset returns all gains to zero, the output limit to 30000,
// the mode flags to error clamp off, separation and integral clamp on,
// and clears the integrator, filter history, previous error and last drive.
module pid_filtered_derivative
   import pfd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   pfd_req_if.sink     req_ch,
   pfd_rsp_if.source   rsp_ch,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   cfg_type            cfg_ff, cfg_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [15:0] rsp_drive_ff, rsp_drive_in;
   logic               idle, start, out_free;
   ctl_type            ctl;
   logic signed [15:0] drive_nxt;

   // Register bank.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_GAIN_P:       cfg_in.gain_p          = signed'(csr_wdata);
            CSR_GAIN_I:       cfg_in.gain_i          = signed'(csr_wdata);
            CSR_GAIN_D:       cfg_in.gain_d          = signed'(csr_wdata);
            CSR_ERROR_MAX:    cfg_in.error_max       = csr_wdata[15:0];
            CSR_SEP_BAND:     cfg_in.separation_band = csr_wdata[15:0];
            CSR_INTEGRAL_MAX: cfg_in.integral_max    = csr_wdata[14:0];
            CSR_OUTPUT_LIMIT: cfg_in.output_limit    = csr_wdata[14:0];
            CSR_MODE_FLAGS:   cfg_in.mode_flags      = csr_wdata[2:0];
            default:          cfg_in                 = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{gain_p: '0, gain_i: '0, gain_d: '0, error_max: '0,
                     separation_band: '0, integral_max: '0,
                     output_limit: OUTPUT_LIMIT_RST, mode_flags: MODE_FLAGS_RST};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Request side: a beat is taken whenever the sequencer is idle.
   assign req_ch.ready = idle;
   assign start        = req_ch.valid && idle;

   // The output register frees up in the same cycle its beat is taken.
   assign out_free = !rsp_valid_ff || rsp_ch.ready;

   pfd_sequencer u_seq (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .func     (req_ch.func),
      .out_free (out_free),
      .idle     (idle),
      .ctl      (ctl)
   );

   pfd_datapath u_dp (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .cfg       (cfg_ff),
      .target    (req_ch.target),
      .measure   (req_ch.measure),
      .drive_nxt (drive_nxt)
   );

   // Output register, loaded by the emitting microcode step.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_drive_in = rsp_drive_ff;
      if (ctl.en && ctl.uw.emit) begin
         rsp_valid_in = 1'b1;
         rsp_drive_in = drive_nxt;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_drive_ff <= rsp_drive_in;
   end

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.drive = rsp_drive_ff;

endmodule

// ===== rtl/pfd_sequencer.sv =====
`timescale 1ns / 1ps
`include "pid_filtered_derivative_macros.svh"
module pfd_sequencer
   import pfd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  logic    func,
   input  logic    out_free,
   output logic    idle,
   output ctl_type ctl
);

   logic       busy_ff, busy_in;
   logic [3:0] step_ff, step_in;
   logic       func_ff, func_in;
   uword_type  uw, uw_run;
   logic       en;

   assign uw   = ucode(step_ff);
   // An emitting step waits until the output register can take the beat.
   assign en   = busy_ff && !(uw.emit && !out_free);
   assign idle = !busy_ff;

   // A clear beat only takes the jump; the error registers keep their values.
   always_comb begin
      uw_run      = uw;
      uw_run.prep = uw.prep && !func_ff;
   end

   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      func_in = func_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = ST_PREP;
         func_in = func;
      end else if (en) begin
         if (uw.last) begin
            busy_in = 1'b0;
         end
         if (uw.jmp_func && func_ff) begin
            step_in = uw.jmp_to;
         end else begin
            step_in = step_ff + 4'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= ST_PREP;
         func_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
         func_ff <= func_in;
      end
   end

   assign ctl.load = start;
   assign ctl.en   = en;
   assign ctl.uw   = uw_run;

   `PFD_ASSERT_NEXT(a_start_prep, start, busy_ff && step_ff == ST_PREP)
   `PFD_ASSERT_NEXT(a_stall_holds, busy_ff && uw.emit && !out_free, busy_ff && $stable(step_ff))
   `PFD_ASSERT_NEXT(a_last_idles, en && uw.last, !busy_ff)

endmodule

// ===== rtl/pfd_datapath.sv =====
`timescale 1ns / 1ps
`include "pid_filtered_derivative_macros.svh"
module pfd_datapath
   import pfd_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  ctl_type            ctl,
   input  cfg_type            cfg,
   input  logic signed [15:0] target,
   input  logic signed [15:0] measure,
   output logic signed [15:0] drive_nxt
);

   logic signed [15:0] tgt_ff, tgt_in, meas_ff, meas_in;
   logic signed [16:0] err_ff, err_in, prev_err_ff, prev_err_in;
   logic signed [17:0] deriv_ff, deriv_in;
   logic signed [17:0] fin0_ff, fin0_in, fin1_ff, fin1_in;
   logic signed [31:0] fout0_ff, fout0_in, fout1_ff, fout1_in;
   logic signed [63:0] prod_ff, prod_in, acc_ff, acc_in;
   logic signed [47:0] integ_ff, integ_in;
   logic signed [15:0] last_drive_ff, last_drive_in;

   logic signed [16:0] err_raw, err_cl;
   logic signed [17:0] emax;
   logic [16:0]        err_abs;
   logic               in_band;
   logic signed [31:0] mul_a, mul_b;
   logic signed [63:0] prod_full;
   logic signed [63:0] yq, dq, kd;
   logic signed [31:0] y_new;
   logic signed [49:0] isum;
   logic signed [47:0] isat, icl;
   logic signed [31:0] imax;
   logic signed [15:0] lim, dcl;

   uword_type uw;
   assign uw = ctl.uw;

   // Error, raw derivative and the optional error clamp.
   assign err_raw = 17'(tgt_ff) - 17'(meas_ff);
   assign emax    = signed'({2'b00, cfg.error_max});
   always_comb begin
      err_cl = err_raw;
      if (cfg.mode_flags[MODE_ERR_CLAMP]) begin
         if (18'(err_raw) > emax) begin
            err_cl = emax[16:0];
         end else if (18'(err_raw) < -emax) begin
            err_cl = 17'(-emax);
         end
      end
   end

   assign err_abs = err_ff[16] ? 17'(-err_ff) : err_ff;
   assign in_band = !cfg.mode_flags[MODE_SEPARATE] || ({1'b0, cfg.separation_band} >= err_abs);

   // Shared multiplier.
   always_comb begin
      case (uw.mul_sel)
         MUL_B0D:  begin mul_a = COEF_B0;    mul_b = 32'(deriv_ff); end
         MUL_B1H0: begin mul_a = COEF_B1;    mul_b = 32'(fin0_ff);  end
         MUL_B2H1: begin mul_a = COEF_B2;    mul_b = 32'(fin1_ff);  end
         MUL_A1Y0: begin mul_a = COEF_NA1;   mul_b = fout0_ff;      end
         MUL_A2Y1: begin mul_a = COEF_NA2;   mul_b = fout1_ff;      end
         MUL_KIE:  begin mul_a = cfg.gain_i; mul_b = 32'(err_ff);   end
         MUL_KPE:  begin mul_a = cfg.gain_p; mul_b = 32'(err_ff);   end
         MUL_KDY:  begin mul_a = cfg.gain_d; mul_b = fout0_ff;      end
         default:  begin mul_a = '0;         mul_b = '0;            end
      endcase
   end
   assign prod_full = mul_a * mul_b;

   // Filter output: round half up from Q42 to Q12, saturate.
   assign yq = (acc_ff + (64'sd1 <<< 29)) >>> 30;
   always_comb begin
      if (yq > 64'(Y_MAX)) begin
         y_new = Y_MAX;
      end else if (yq < -64'(Y_MAX)) begin
         y_new = -Y_MAX;
      end else begin
         y_new = yq[31:0];
      end
   end

   // Integrator accumulate with saturation, then the optional band clamp.
   assign isum = 50'(integ_ff) + 50'(signed'(prod_ff[48:0]));
   always_comb begin
      if (isum > 50'(INTEG_HI)) begin
         isat = INTEG_HI;
      end else if (isum < 50'(INTEG_LO)) begin
         isat = INTEG_LO;
      end else begin
         isat = isum[47:0];
      end
   end

   assign imax = signed'({1'b0, cfg.integral_max, 16'd0});
   always_comb begin
      icl = integ_ff;
      if (cfg.mode_flags[MODE_INT_CLAMP]) begin
         if (integ_ff > 48'(imax)) begin
            icl = 48'(imax);
         end else if (integ_ff < -48'(imax)) begin
            icl = -48'(imax);
         end
      end
   end

   assign kd = (prod_ff + 64'sd2048) >>> 12;

   // Output: round half up from Q16 and clamp to the limit.
   assign dq  = (acc_ff + 64'sd32768) >>> 16;
   assign lim = signed'({1'b0, cfg.output_limit});
   always_comb begin
      if (dq > 64'(lim)) begin
         dcl = lim;
      end else if (dq < -64'(lim)) begin
         dcl = -lim;
      end else begin
         dcl = dq[15:0];
      end
   end
   assign drive_nxt = uw.clr_int ? last_drive_ff : dcl;

   always_comb begin
      tgt_in        = tgt_ff;
      meas_in       = meas_ff;
      err_in        = err_ff;
      prev_err_in   = prev_err_ff;
      deriv_in      = deriv_ff;
      fin0_in       = fin0_ff;
      fin1_in       = fin1_ff;
      fout0_in      = fout0_ff;
      fout1_in      = fout1_ff;
      prod_in       = prod_ff;
      acc_in        = acc_ff;
      integ_in      = integ_ff;
      last_drive_in = last_drive_ff;
      if (ctl.load) begin
         tgt_in  = target;
         meas_in = measure;
      end
      if (ctl.en) begin
         if (uw.prep) begin
            err_in      = err_cl;
            deriv_in    = 18'(err_raw) - 18'(prev_err_ff);
            prev_err_in = err_cl;
         end
         if (uw.mul_en) begin
            prod_in = prod_full;
         end
         case (uw.acc_op)
            ACC_LOAD:   acc_in = prod_ff;
            ACC_ADD:    acc_in = acc_ff + prod_ff;
            ACC_LOAD12: acc_in = prod_ff <<< 12;
            ACC_ADD12:  acc_in = acc_ff + (prod_ff <<< 12);
            ACC_ADDI:   acc_in = acc_ff + 64'(integ_ff);
            ACC_ADDKD:  acc_in = acc_ff + kd;
            default:    acc_in = acc_ff;
         endcase
         if (uw.y_upd) begin
            fin1_in  = fin0_ff;
            fin0_in  = deriv_ff;
            fout1_in = fout0_ff;
            fout0_in = y_new;
         end
         if (uw.int_add && in_band) begin
            integ_in = isat;
         end
         if (uw.int_clamp) begin
            integ_in = icl;
         end
         if (uw.clr_int) begin
            integ_in = '0;
         end
         if (uw.emit && !uw.clr_int) begin
            last_drive_in = dcl;
         end
      end
   end

   always_ff @(posedge clock) begin
      tgt_ff  <= tgt_in;
      meas_ff <= meas_in;
      err_ff  <= err_in;
      deriv_ff <= deriv_in;
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_err_ff   <= '0;
         fin0_ff       <= '0;
         fin1_ff       <= '0;
         fout0_ff      <= '0;
         fout1_ff      <= '0;
         integ_ff      <= '0;
         last_drive_ff <= '0;
      end else begin
         prev_err_ff   <= prev_err_in;
         fin0_ff       <= fin0_in;
         fin1_ff       <= fin1_in;
         fout0_ff      <= fout0_in;
         fout1_ff      <= fout1_in;
         integ_ff      <= integ_in;
         last_drive_ff <= last_drive_in;
      end
   end

   `PFD_ASSERT_NEXT(a_int_bound, ctl.en && uw.int_clamp && cfg.mode_flags[MODE_INT_CLAMP], (integ_ff <= 48'(imax)) && (integ_ff >= -48'(imax)))

endmodule
